// ===== design/max_pool_2x2_stride2_assert.svh =====
// Assertion macros for the pooling block.
`ifndef MAX_POOL_2X2_STRIDE2_ASSERT_SVH
`define MAX_POOL_2X2_STRIDE2_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("assert");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assert");
`else
`define ASSERT_IMPL(label, cond)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/mp2x2_pkg.sv =====
// ----------------------------------------------------------------------------
// mp2x2_pkg
// Constants, register indexes and the IEEE maxNum function for pooling.
// ----------------------------------------------------------------------------
`default_nettype none
package mp2x2_pkg;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;
    localparam logic [31:0] CANON_NAN = 32'h7fc00000;
    localparam logic [31:0] POS_ZERO = 32'h00000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH = 3'd0,
        REG_IN_HEIGHT = 3'd1,
        REG_PAD_LEFT_TOP = 3'd2,
        REG_PAD_RIGHT = 3'd3,
        REG_PAD_BOTTOM = 3'd4
    } cfg_idx_t;

    function automatic logic [31:0] fmax_bits(input logic [31:0] a, input logic [31:0] b);
        logic na;
        logic nb;
        logic [31:0] ka;
        logic [31:0] kb;
        na = (a[30:0] > 31'h7f800000);
        nb = (b[30:0] > 31'h7f800000);
        ka = a[31] ? ~a : (a | 32'h80000000);
        kb = b[31] ? ~b : (b | 32'h80000000);
        if (na && nb)
            fmax_bits = CANON_NAN;
        else if (na)
            fmax_bits = b;
        else if (nb)
            fmax_bits = a;
        else
            fmax_bits = (ka >= kb) ? a : b;
    endfunction
endpackage
`default_nettype wire

// ===== design/max_pool_2x2_stride2.sv =====
// A pooled result is registered and shows on m_axis the cycle after its last pixel is taken.
// Throughput: one pixel per cycle while s_axis_tready is high; the line buffer is written
// at most once and read once per cycle, the read registered one request ahead of its pixel.
// The output register acts as a single stage; input is held off only while it is full
// and not being taken.
// Reset clears counters, geometry registers and the output valid; buffers are not cleared.
// ----------------------------------------------------------------------------
// max_pool_2x2_stride2
// Streaming 2x2 stride-2 max pooling of fp32 planes with optional zero padding.
// ----------------------------------------------------------------------------
`default_nettype none
`include "max_pool_2x2_stride2_assert.svh"
module max_pool_2x2_stride2
    import mp2x2_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [31:0]           s_axis_tdata,  // [31:0] pixel
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [31:0]                m_axis_tdata,  // [31:0] pooled
    output logic                       m_axis_tlast   // plane_end
);
    localparam int DEPTH = MAX_WIDTH / 2 + 1;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(MAX_WIDTH + 2);

    logic [CW-1:0] width_reg;
    logic [10:0]   height_reg;
    logic          pad_lt_reg, pad_r_reg, pad_b_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [10:0]   row_reg, row_next;
    logic [31:0]   left_reg;
    logic [31:0]   line_mem [DEPTH];
    logic [31:0]   line_rd_reg;
    logic [31:0]   out_data_reg;
    logic          out_last_reg, out_valid_reg;

    logic          acc;
    logic [CW-1:0] wp, pc, ow, pc_next;
    logic [11:0]   hp, pr, oh;
    logic          pad_rx, pad_bx, have_pair, emit, wr_line, last;
    logic [31:0]   pair, result, up;
    logic [AW-1:0] j, j_next, rd_addr;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign acc = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        wp = width_reg + CW'(pad_lt_reg);
        hp = {1'b0, height_reg} + 12'(pad_lt_reg);
        pad_rx = pad_r_reg & wp[0];
        pad_bx = pad_b_reg & hp[0];
        ow = (wp + CW'(pad_rx)) >> 1;
        oh = (hp + 12'(pad_bx)) >> 1;
        pc = col_reg + CW'(pad_lt_reg);
        pr = {1'b0, row_reg} + 12'(pad_lt_reg);
        have_pair = 1'b0;
        pair = POS_ZERO;
        if (pc[0])
        begin
            pair = fmax_bits((pc == CW'(1) && pad_lt_reg) ? POS_ZERO : left_reg,
                s_axis_tdata);
            have_pair = 1'b1;
        end
        else if (pc == wp - CW'(1))
        begin
            pair = fmax_bits(s_axis_tdata, POS_ZERO);
            have_pair = pad_rx;
        end
        j = AW'(pc >> 1);
        up = (pr == 12'd1 && pad_lt_reg) ? POS_ZERO : line_rd_reg;
        emit = 1'b0;
        wr_line = 1'b0;
        result = fmax_bits(pair, POS_ZERO);
        if (pr[0])
        begin
            result = fmax_bits(up, pair);
            emit = have_pair;
        end
        else if (pr == hp - 12'd1)
            emit = have_pair && pad_bx;
        else
            wr_line = have_pair;
        last = ((pc >> 1) == ow - CW'(1)) && ((pr >> 1) == oh - 12'd1);
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (col_next >= width_reg)
        begin
            col_next = '0;
            row_next = (row_reg + 11'd1 >= height_reg) ? 11'd0 : row_reg + 11'd1;
        end
        // The buffer is read at the pair index of the request that is due next.
        pc_next = col_next + CW'(pad_lt_reg);
        j_next = AW'(pc_next >> 1);
        rd_addr = cfg_we ? '0 : (acc ? j_next : j);
    end

    always_ff @(posedge clk)
    begin
        if (acc && wr_line)
            line_mem[j] <= pair;
        if (acc && wr_line && j == rd_addr)
            line_rd_reg <= pair;
        else
            line_rd_reg <= line_mem[rd_addr];
        if (acc && !pc[0])
            left_reg <= s_axis_tdata;
        if (acc && emit)
        begin
            out_data_reg <= result;
            out_last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= CW'(8);
            height_reg <= 11'd8;
            pad_lt_reg <= 1'b0;
            pad_r_reg <= 1'b0;
            pad_b_reg <= 1'b0;
            col_reg <= '0;
            row_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                out_valid_reg <= emit;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IN_WIDTH:
                    begin
                        if (cfg_data == '0)
                            width_reg <= CW'(1);
                        else if (32'(cfg_data) > 32'(MAX_WIDTH))
                            width_reg <= CW'(MAX_WIDTH);
                        else
                            width_reg <= CW'(cfg_data);
                    end
                    REG_IN_HEIGHT: height_reg <= (cfg_data == '0) ? 11'd1 : cfg_data;
                    REG_PAD_LEFT_TOP: pad_lt_reg <= cfg_data[0];
                    REG_PAD_RIGHT: pad_r_reg <= cfg_data[0];
                    REG_PAD_BOTTOM: pad_b_reg <= cfg_data[0];
                    default: ;
                endcase
                if (cfg_index <= REG_PAD_BOTTOM)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tlast = out_last_reg;

    `ASSERT_IMPL(a_col_range, col_reg < width_reg)
    `ASSERT_IMPL(a_row_range, row_reg < height_reg)
    `ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_NEXT(a_odd_pix, acc && !pc[0] && !(pc == wp - CW'(1)), !m_axis_tvalid)
endmodule
`default_nettype wire
